// ===== src/dro_pkg.sv =====
// ----------------------------------------------------------------------------
// dro_pkg
// Shared types and constants of the divider ohmmeter.
// ----------------------------------------------------------------------------
package dro_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 20;
    localparam int AVG_W       = 15;
    localparam int REF_W       = 20;
    localparam int ADC_W       = 24;
    localparam int RES_W       = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int OUT_DATA_W  = 48;

    // samples per block, a power of two so the mean is a shift
    localparam int AVG_COUNT = 32;
    localparam int AVG_SHIFT = 5;
    localparam int COUNT_W   = 5;

    localparam int PROD_W = ADC_W + AVG_W;        // Radc*avg, Radc*(fs-avg)
    localparam int NEG_W  = REF_W + AVG_W;        // Rref*avg
    localparam int NUM_W  = REF_W + ADC_W + AVG_W; // Rref*Radc*avg
    localparam int HI_W   = PROD_W - REF_W;       // upper slice of Radc*avg

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'd32767;
    localparam logic [REF_W-1:0]    REF_RESET  = 20'd9950;
    localparam logic [ADC_W-1:0]    ADC_RESET  = 24'd293053;

    localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADC_INPUT = 2'd1;

    typedef struct packed {
        logic sample_en;   // add accepted sample to the running sum
        logic block_end;   // this sample closes the block
        logic mul1;        // Rref*avg, Radc*avg, full scale minus avg
        logic mul2;        // Radc*(fs-avg) and numerator partial products
        logic sum;         // numerator and denominator
        logic div_init;    // load divider, range check
        logic div_step;    // one quotient bit
        logic load;        // move result to output register
    } dro_cmd_t;

    typedef struct packed {
        logic out_busy;    // output register holds an item not taken this cycle
    } dro_stat_t;

endpackage

// ===== src/dro_ctrl.sv =====
// ----------------------------------------------------------------------------
// dro_ctrl
// Sequencer: counts samples per block and steps the datapath through the
// multiply, divide and output phases.
// ----------------------------------------------------------------------------
module dro_ctrl
    import dro_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dro_stat_t stat,
    output dro_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_DINIT,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(AVG_COUNT - 1);
    localparam logic [COUNT_W-1:0] LAST_STEP  = COUNT_W'(RES_W - 1);

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] step_reg, step_next;
    logic               accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.sample_en = 1'b1;
                    if (count_reg == LAST_COUNT)
                    begin
                        cmd.block_end = 1'b1;
                        count_next    = '0;
                        state_next    = ST_MUL1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== src/dro_dp.sv =====
// ----------------------------------------------------------------------------
// dro_dp
// Datapath: configuration registers, running sum, staged multiplies,
// restoring divider and output register.
// ----------------------------------------------------------------------------
module dro_dp
    import dro_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [SAMPLE_W-1:0]    sample_code,
    input  dro_cmd_t               cmd,
    output dro_stat_t              stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tuser
);

    logic [REF_W-1:0]  ref_reg;
    logic [ADC_W-1:0]  adc_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [SAMPLE_W-1:0] code_q;

    logic [AVG_W-1:0]  avg_reg;
    logic [AVG_W-1:0]  diff_reg;
    logic [NEG_W-1:0]  neg_reg;
    logic [PROD_W-1:0] radc_avg_reg;
    logic [PROD_W-1:0] pos_reg;
    logic [2*REF_W-1:0] numa_reg;
    logic [HI_W+REF_W-1:0] numb_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [PROD_W-1:0] den_reg;
    logic              den_nonpos_reg;
    logic              quo_ovf_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [RES_W-1:0]  quo_reg;

    logic [PROD_W:0]   trial;
    logic              trial_ge;

    logic              out_valid_reg;
    logic [RES_W-1:0]  out_res_reg;
    logic [AVG_W-1:0]  out_avg_reg;
    logic              out_ovr_reg;

    // configuration, written only while idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= REF_RESET;
            adc_reg <= ADC_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_REFERENCE)
            begin
                ref_reg <= cfg_data[REF_W-1:0];
            end
            else if (cfg_index == REG_ADC_INPUT)
            begin
                adc_reg <= cfg_data[ADC_W-1:0];
            end
        end
    end

    // codes at or above full scale count as zero
    assign code_q   = (sample_code >= FULL_SCALE) ? '0 : sample_code;
    assign sum_next = sum_reg + SUM_W'(code_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sample_en)
        begin
            sum_reg <= cmd.block_end ? '0 : sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sample_en && cmd.block_end)
        begin
            avg_reg <= sum_next[SUM_W-1 -: AVG_W];
        end
    end

    // arithmetic stages
    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            neg_reg      <= NEG_W'(ref_reg) * NEG_W'(avg_reg);
            radc_avg_reg <= PROD_W'(adc_reg) * PROD_W'(avg_reg);
            diff_reg     <= FULL_SCALE[AVG_W-1:0] - avg_reg;
        end
        if (cmd.mul2)
        begin
            pos_reg  <= PROD_W'(adc_reg) * PROD_W'(diff_reg);
            numa_reg <= (2*REF_W)'(radc_avg_reg[REF_W-1:0]) * (2*REF_W)'(ref_reg);
            numb_reg <= (HI_W+REF_W)'(radc_avg_reg[PROD_W-1:REF_W])
                        * (HI_W+REF_W)'(ref_reg);
        end
        if (cmd.sum)
        begin
            num_reg        <= NUM_W'(numa_reg) + (NUM_W'(numb_reg) << REF_W);
            den_reg        <= pos_reg - PROD_W'(neg_reg);
            den_nonpos_reg <= (pos_reg <= PROD_W'(neg_reg));
        end
    end

    // restoring divider, one quotient bit per step; low numerator bits leave the top
    // of the quotient register for the remainder as quotient bits enter at the bottom
    assign trial    = {rem_reg, quo_reg[RES_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg     <= PROD_W'(num_reg[NUM_W-1:RES_W]);
            quo_reg     <= num_reg[RES_W-1:0];
            quo_ovf_reg <= (PROD_W'(num_reg[NUM_W-1:RES_W]) >= den_reg);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? PROD_W'(trial - {1'b0, den_reg}) : trial[PROD_W-1:0];
            quo_reg <= {quo_reg[RES_W-2:0], trial_ge};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_avg_reg <= avg_reg;
            if (avg_reg == '0)
            begin
                out_res_reg <= '0;
                out_ovr_reg <= 1'b0;
            end
            else if (den_nonpos_reg || quo_ovf_reg)
            begin
                out_res_reg <= '1;
                out_ovr_reg <= 1'b1;
            end
            else
            begin
                out_res_reg <= quo_reg;
                out_ovr_reg <= 1'b0;
            end
        end
    end

    assign stat.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {{(OUT_DATA_W-RES_W-AVG_W){1'b0}}, out_avg_reg, out_res_reg};
    assign m_tuser       = out_ovr_reg;

endmodule

// ===== src/divider_resistance_ohmmeter_top.sv =====
// Sequence: after a block's last sample is accepted its result passes through
// three multiply/add stages, divider load, 32 divide steps and the output register.
// Throughput: one sample per cycle within a block; after the last sample of a
// block, input stalls until the bit-serial 32-step divider's result is loaded.
// Reset: rst_n clears sum, count and output valid and restores the register
// defaults (reference 9950 ohms, ADC input 293053 ohms).
// ----------------------------------------------------------------------------
// divider_resistance_ohmmeter_top
// Block-averaging ohmmeter for a reference-resistor divider read by an ADC
// with finite input resistance.
// ----------------------------------------------------------------------------
module divider_resistance_ohmmeter_top
    import dro_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // sample stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_W-1:0]    s_tdata,   // [15:0] sample_code
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // [31:0] resistance_ohms,
                                              // [46:32] average_code, [47] zero
    output logic                   m_tuser    // [0] over_range
);

    dro_cmd_t  cmd;
    dro_stat_t stat;

    // register writes wait while a block result is being computed
    assign cfg_ready = s_tready;

    dro_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dro_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_code (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== sim/divider_resistance_ohmmeter_top_tb.sv =====
// ----------------------------------------------------------------------------
// divider_resistance_ohmmeter_top_tb
// Self-checking bench for the divider ohmmeter. A table of constant-code blocks
// covers the field extremes and the saturation and zero cases. Random phases
// follow, each with a new register setting and noisy codes around a random
// level. Every reading is checked against a bit-true predictor of the block
// averager and resistance solver, or a pinned row's typed-in reading.
// ----------------------------------------------------------------------------
module divider_resistance_ohmmeter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dro_pkg::*;

    localparam int RANDOM_SAMPLES   = 1320;
    localparam int SETTLE_CYCLES    = 45;    // result latency plus margin
    localparam int LONG_HOLD_CYCLES = 1000;
    localparam int ROWS             = 12;

    // indexes past the register list, writes to them are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [RES_W-1:0] OHMS_SATURATED = '1;

    typedef struct packed {
        logic [RES_W-1:0] ohms;
        logic [AVG_W-1:0] avg;
        logic             ovr;
    } reading_t;

    typedef struct packed {
        logic                  wr_ref;
        logic [CFG_DATA_W-1:0] ref_data;
        logic                  wr_adc;
        logic [CFG_DATA_W-1:0] adc_data;
        logic [SAMPLE_W-1:0]   code;      // sent 32 times, one full block
        logic                  pinned;    // reading below is typed in
        reading_t              reading;
    } block_row_t;

    block_row_t directed_rows [ROWS] = '{
        '{1'b0, 24'd0, 1'b0, 24'd0, 16'd0, 1'b1, '{32'd0, 15'd0, 1'b0}},
        '{1'b0, 24'd0, 1'b0, 24'd0, 16'd32767, 1'b1, '{32'd0, 15'd0, 1'b0}},
        '{1'b0, 24'd0, 1'b0, 24'd0, 16'd65535, 1'b1, '{32'd0, 15'd0, 1'b0}},
        '{1'b0, 24'd0, 1'b0, 24'd0, 16'd32766, 1'b1,
          '{32'hFFFF_FFFF, 15'd32766, 1'b1}},
        '{1'b0, 24'd0, 1'b0, 24'd0, 16'd16383, 1'b0, '{32'd0, 15'd0, 1'b0}},
        '{1'b0, 24'd0, 1'b0, 24'd0, 16'd12345, 1'b0, '{32'd0, 15'd0, 1'b0}},
        // zero reference: numerator vanishes
        '{1'b1, 24'd0, 1'b0, 24'd0, 16'd1000, 1'b1, '{32'd0, 15'd1000, 1'b0}},
        // zero ADC resistance: denominator not positive
        '{1'b1, 24'd9950, 1'b1, 24'd0, 16'd1, 1'b1, '{32'hFFFF_FFFF, 15'd1, 1'b1}},
        // reference written with bits above its width
        '{1'b1, 24'hFF_FFFF, 1'b1, 24'hFF_FFFF, 16'd1, 1'b0, '{32'd0, 15'd0, 1'b0}},
        // small positive denominator, quotient beyond 32 bits
        '{1'b0, 24'd0, 1'b0, 24'd0, 16'd30839, 1'b1,
          '{32'hFFFF_FFFF, 15'd30839, 1'b1}},
        '{1'b1, 24'd1, 1'b1, 24'd1, 16'd32766, 1'b1,
          '{32'hFFFF_FFFF, 15'd32766, 1'b1}},
        '{1'b1, 24'd9950, 1'b1, 24'd293053, 16'd20000, 1'b0, '{32'd0, 15'd0, 1'b0}}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;

    // predictor state
    logic [REF_W-1:0]   ref_ohms;
    logic [ADC_W-1:0]   adc_ohms;
    logic [SUM_W-1:0]   code_sum;
    logic [COUNT_W-1:0] code_count;
    reading_t           pending_readings [$];
    logic               pin_valid;
    reading_t           pin_reading;

    int   mismatches;
    logic hold_req;
    logic no_idle;

    divider_resistance_ohmmeter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // Accumulate one code; on the last code of a block queue the reading.
    function automatic void take_sample(input logic [SAMPLE_W-1:0] code);
        logic [SAMPLE_W-1:0] qualified;
        logic [AVG_W-1:0]    mean;
        logic [63:0]         num;
        logic [63:0]         pos;
        logic [63:0]         neg;
        logic [63:0]         quo;
        reading_t            r;
        qualified = (code >= FULL_SCALE) ? '0 : code;
        code_sum  = code_sum + SUM_W'(qualified);
        if (code_count != COUNT_W'(AVG_COUNT - 1))
        begin
            code_count = code_count + 1'b1;
            return;
        end
        mean       = AVG_W'(code_sum >> AVG_SHIFT);
        code_sum   = '0;
        code_count = '0;
        r = '{ohms: '0, avg: mean, ovr: 1'b0};
        if (mean != '0)
        begin
            num = 64'(ref_ohms) * 64'(adc_ohms) * 64'(mean);
            pos = 64'(adc_ohms) * (64'(FULL_SCALE) - 64'(mean));
            neg = 64'(ref_ohms) * 64'(mean);
            if (pos <= neg)
            begin
                r.ohms = OHMS_SATURATED;
                r.ovr  = 1'b1;
            end
            else
            begin
                quo = num / (pos - neg);
                if (quo > 64'(OHMS_SATURATED))
                begin
                    r.ohms = OHMS_SATURATED;
                    r.ovr  = 1'b1;
                end
                else
                    r.ohms = quo[RES_W-1:0];
            end
        end
        if (pin_valid)
        begin
            r         = pin_reading;
            pin_valid = 1'b0;
        end
        pending_readings.push_back(r);
    endfunction

    always @(posedge clk)
    begin : monitor
        reading_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_REFERENCE)
                    ref_ohms = cfg_data[REF_W-1:0];
                else if (cfg_index == REG_ADC_INPUT)
                    adc_ohms = cfg_data[ADC_W-1:0];
            end
            if (s_tvalid && s_tready)
                take_sample(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (pending_readings.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected reading tdata=%h tuser=%b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (m_tdata[31:0] !== want.ohms)
                    begin
                        mismatches++;
                        $display("%0t: resistance_ohms expected %0d got %0d",
                                 $time, want.ohms, m_tdata[31:0]);
                    end
                    if (m_tdata[46:32] !== want.avg)
                    begin
                        mismatches++;
                        $display("%0t: average_code expected %0d got %0d",
                                 $time, want.avg, m_tdata[46:32]);
                    end
                    if (m_tdata[47] !== 1'b0)
                    begin
                        mismatches++;
                        $display("%0t: tdata pad bit expected 0 got %b",
                                 $time, m_tdata[47]);
                    end
                    if (m_tuser !== want.ovr)
                    begin
                        mismatches++;
                        $display("%0t: over_range expected %b got %b",
                                 $time, want.ovr, m_tuser);
                    end
                end
            end
        end
    end

    // result side: a random stall before each item, none while no_idle is set, or one long hold on request
    initial
    begin : reader
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                n        = LONG_HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                n = no_idle ? 0 : $urandom_range(0, 3);
            @(negedge clk);
            if (n != 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] code);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, wait for every queued reading, then let the pipe settle
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                  phase;
        int                  n;
        int                  center;
        int                  c;
        int                  pick;
        int                  samples_sent;
        int unsigned         ref_val;
        int unsigned         adc_val;
        int unsigned         adc_lo;
        logic [SAMPLE_W-1:0] code;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        hold_req   = 1'b0;
        no_idle    = 1'b0;
        pin_valid  = 1'b0;
        pin_reading = '0;
        mismatches = 0;
        ref_ohms   = REF_RESET;
        adc_ohms   = ADC_RESET;
        code_sum   = '0;
        code_count = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            wait_idle();
            if (directed_rows[i].wr_ref)
                write_register(REG_REFERENCE, directed_rows[i].ref_data);
            if (directed_rows[i].wr_adc)
                write_register(REG_ADC_INPUT, directed_rows[i].adc_data);
            pin_valid   = directed_rows[i].pinned;
            pin_reading = directed_rows[i].reading;
            repeat (AVG_COUNT) send_sample(directed_rows[i].code);
        end

        phase        = 0;
        samples_sent = 0;
        while (samples_sent < RANDOM_SAMPLES)
        begin
            wait_idle();
            pick = $urandom_range(0, 7);
            case (pick)
                0:
                begin
                    ref_val = 1;
                    adc_val = 16777215;
                end
                1:
                begin
                    ref_val = 1048575;
                    adc_val = 16777215;
                end
                2:
                begin
                    ref_val = $urandom_range(1, 1000);
                    adc_val = 1;
                end
                3:
                begin
                    ref_val = REF_RESET;
                    adc_val = ADC_RESET;
                end
                default:
                begin
                    // Radc well above Rref keeps most readings in range
                    ref_val = $urandom_range(1, 200000);
                    adc_lo  = ref_val * 16;
                    adc_val = $urandom_range(adc_lo, 16777215);
                end
            endcase
            write_register(REG_REFERENCE, CFG_DATA_W'(ref_val)
                           | (CFG_DATA_W'($urandom_range(0, 15)) << REF_W));
            write_register(REG_ADC_INPUT, CFG_DATA_W'(adc_val));
            if ($urandom_range(0, 3) == 0)
                write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                               CFG_DATA_W'($urandom));

            no_idle = (phase % 5 == 3);
            if (phase == 1)
            begin
                // sender keeps going while the result side holds off
                hold_req = 1'b1;
                no_idle  = 1'b1;
                n        = 200;
            end
            else
                n = $urandom_range(16, 120);

            center = $urandom_range(0, 32766);
            repeat (n)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    code = SAMPLE_W'($urandom);
                else if (pick == 1)
                    code = SAMPLE_W'($urandom_range(32767, 65535));
                else if (pick == 2)
                    code = $urandom_range(0, 1) ? 16'd32766 : 16'd0;
                else
                begin
                    c = center + int'($urandom_range(0, 128)) - 64;
                    if (c < 0)
                        c = 0;
                    if (c > 32766)
                        c = 32766;
                    code = SAMPLE_W'(c);
                end
                send_sample(code);
                samples_sent++;
            end
            phase++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("divider_resistance_ohmmeter_top_tb OK");
        else
            $display("divider_resistance_ohmmeter_top_tb NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("divider_resistance_ohmmeter_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
src/dro_pkg.sv
src/dro_ctrl.sv
src/dro_dp.sv
src/divider_resistance_ohmmeter_top.sv
sim/divider_resistance_ohmmeter_top_tb.sv
